>>> rtl/core/pnr_pkg.sv
// ---------------------------------------------------------------------------
// pnr_pkg: shared types, constants and helpers
// Fixed widths, op and register codes, sequencer states and the saturating
// and rounding arithmetic of the polyphase NCO resampler.
// ---------------------------------------------------------------------------
package pnr_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int TAP_W       = 5;
  localparam int BR_W        = 6;
  localparam int COEF_AW     = BR_W + TAP_W;
  localparam int COEF_DEPTH  = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 40;
  localparam int PROD_BITS   = 32;
  localparam int GAIN_BITS   = 16;
  localparam int GPROD_BITS  = 57;
  localparam int CNT_W       = 6;
  localparam int RND_W       = 26;
  localparam int MAX_PBITS   = 6;

  localparam logic [31:0] MIN_INTERP_INC = 32'h0400_0000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [GPROD_BITS-1:0]  gprod_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_INTERP_MODE = 3'd0,
    CFG_PHASE_INC   = 3'd1,
    CFG_PHASE_BITS  = 3'd2,
    CFG_TAPS        = 3'd3,
    CFG_DECIM_GAIN  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_POST,
    ST_DUMP,
    ST_GAIN,
    ST_EMIT
  } state_t;

  function automatic acc_t sat_add(acc_t a, acc_t b);
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

  function automatic sample_t sat_sample(logic signed [RND_W-1:0] v);
    if (v > $signed(RND_W'(32767))) begin
      sat_sample = 16'sh7fff;
    end else if (v < -$signed(RND_W'(32768))) begin
      sat_sample = 16'sh8000;
    end else begin
      sat_sample = v[SAMPLE_BITS-1:0];
    end
  endfunction

  // round half up, then >>15
  function automatic sample_t round_acc(acc_t a);
    logic signed [ACC_BITS:0] t;
    t = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(16384);
    round_acc = sat_sample(t[ACC_BITS:15]);
  endfunction

  // round half up, then >>31
  function automatic sample_t round_gain(gprod_t g);
    gprod_t t;
    t = g + GPROD_BITS'(64'h4000_0000);
    round_gain = sat_sample(t[GPROD_BITS-1:31]);
  endfunction

  function automatic logic [BR_W-1:0] branch_of(logic [31:0] ph, logic [2:0] bits);
    logic [2:0] b;
    b = (bits > 3'(MAX_PBITS)) ? 3'(MAX_PBITS) : bits;
    branch_of = ph[31:32-BR_W] >> (3'(MAX_PBITS) - b);
  endfunction

  function automatic logic [CNT_W-1:0] taps_now(logic [CNT_W-1:0] t);
    if (t == '0) begin
      taps_now = CNT_W'(1);
    end else if (t > CNT_W'(MAX_TAPS)) begin
      taps_now = CNT_W'(MAX_TAPS);
    end else begin
      taps_now = t;
    end
  endfunction

endpackage

>>> rtl/core/pnr_in_if.sv
// ---------------------------------------------------------------------------
// pnr_in_if: input item channel
// Valid/ready channel carrying op, sample and coefficient fields.
// ---------------------------------------------------------------------------
interface pnr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [15:0] sample_i;
  logic signed [15:0] sample_q;
  logic [5:0]        coef_branch;
  logic [4:0]        coef_tap;
  logic signed [15:0] coef_value;

  modport source (output valid, op, sample_i, sample_q, coef_branch, coef_tap, coef_value,
                  input ready);
  modport sink (input valid, op, sample_i, sample_q, coef_branch, coef_tap, coef_value,
                output ready);
endinterface

>>> rtl/core/pnr_out_if.sv
// ---------------------------------------------------------------------------
// pnr_out_if: result item channel
// Valid/ready channel carrying one complex result and its last flag.
// ---------------------------------------------------------------------------
interface pnr_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic              last;

  modport source (output valid, out_i, out_q, last, input ready);
  modport sink (input valid, out_i, out_q, last, output ready);
endinterface

>>> rtl/core/pnr_coef_ram.sv
// ---------------------------------------------------------------------------
// pnr_coef_ram: coefficient store
// Single write port, one registered read port, branch-major addressing.
// ---------------------------------------------------------------------------
module pnr_coef_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [pnr_pkg::COEF_AW-1:0] waddr,
  input  pnr_pkg::sample_t            wdata,
  input  logic [pnr_pkg::COEF_AW-1:0] raddr,
  output pnr_pkg::sample_t            rdata
);

  pnr_pkg::sample_t mem [pnr_pkg::COEF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pnr_mac.sv
// ---------------------------------------------------------------------------
// pnr_mac: shared complex multiply-accumulate
// Registered I/Q products, then a saturating add onto a selected addend.
// ---------------------------------------------------------------------------
module pnr_mac (
  input  logic             clk,
  input  logic             en,
  input  pnr_pkg::sample_t coef,
  input  pnr_pkg::sample_t x_i,
  input  pnr_pkg::sample_t x_q,
  input  pnr_pkg::acc_t    add_i,
  input  pnr_pkg::acc_t    add_q,
  output pnr_pkg::acc_t    sum_i,
  output pnr_pkg::acc_t    sum_q
);

  pnr_pkg::prod_t prod_i_r;
  pnr_pkg::prod_t prod_q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_i_r <= x_i * coef;
      prod_q_r <= x_q * coef;
    end
  end

  assign sum_i = pnr_pkg::sat_add(add_i, pnr_pkg::ACC_BITS'(prod_i_r));
  assign sum_q = pnr_pkg::sat_add(add_q, pnr_pkg::ACC_BITS'(prod_q_r));

endmodule

>>> rtl/core/polyphase_nco_resampler.sv
// ---------------------------------------------------------------------------
// polyphase_nco_resampler: complex polyphase resampler with NCO branch select
// Interpolating or transposed-decimating IQ resampler, one shared MAC.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries items: sample (op 0), coefficient write (op 1), clear (op 2).
//   out_ch carries result items (out_i, out_q, last); last marks the final
//   result of an input item. cfg_we/cfg_idx/cfg_wdata write the registers
//   while the block is idle.
// Timing:
//   Coefficient write, clear and unused ops are taken while the sequencer
//   stays idle. A sample is accepted in idle, then walks the taps through
//   one complex MAC, one tap per cycle, with a registered coefficient read
//   and a registered product, followed by a post state. Interpolation runs
//   one pass per result, one result per NCO step until carry. Decimation
//   runs one pass per sample, plus dump, gain multiply and rounding steps
//   on carry.
//   in_ch.ready is high only while the sequencer is idle.
// Reset: rst_n (synchronous) restores register defaults and zeroes the phase,
//   delay line, integrators and transposed line; coefficients are not cleared.
// Stall: a result waits in the output register; the sequencer holds before
//   loading the next result until it is taken.
// ---------------------------------------------------------------------------
module polyphase_nco_resampler (
  input  logic             clk,
  input  logic             rst_n,
  pnr_in_if.sink           in_ch,
  pnr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [31:0]      cfg_wdata
);

  localparam int NT = pnr_pkg::MAX_TAPS;
  localparam int TW = pnr_pkg::TAP_W;
  localparam int CW = pnr_pkg::CNT_W;

  pnr_pkg::state_t state_r, state_nxt;

  logic        mode_r;
  logic [31:0] inc_r;
  logic [2:0]  pbits_r;
  logic [5:0]  taps_r;
  logic [15:0] gain_r;

  logic [31:0]      phase_r;
  logic [TW-1:0]    head_r;
  pnr_pkg::sample_t dl_i_r [NT];
  pnr_pkg::sample_t dl_q_r [NT];
  pnr_pkg::acc_t    integ_i_r [NT];
  pnr_pkg::acc_t    integ_q_r [NT];
  pnr_pkg::acc_t    tdl_i_r [NT-1];
  pnr_pkg::acc_t    tdl_q_r [NT-1];
  pnr_pkg::sample_t x_i_r, x_q_r;
  logic [CW-1:0]    j_r;
  logic             s1_v_r, s2_v_r;
  logic [TW-1:0]    s1_j_r, s2_j_r;
  pnr_pkg::sample_t opnd_i_r, opnd_q_r;
  pnr_pkg::acc_t    acc_i_r, acc_q_r;
  pnr_pkg::acc_t    y_i_r, y_q_r;
  pnr_pkg::gprod_t  g_i_r, g_q_r;

  logic             out_valid_r, out_last_r;
  pnr_pkg::sample_t out_i_r, out_q_r;

  logic [CW-1:0]               n;
  logic [pnr_pkg::BR_W-1:0]    branch;
  logic [31:0]                 inc_eff;
  logic [32:0]                 next_phase;
  logic                        carry;
  logic [CW-1:0]               rev_j;
  logic [TW-1:0]               tap_addr;
  logic [TW-1:0]               dl_idx;
  logic                        issue;
  logic                        in_acc;
  logic                        slot_free;
  logic                        walk_done;
  logic                        out_load;
  pnr_pkg::sample_t            coef_q;
  pnr_pkg::acc_t               add_i, add_q, sum_i, sum_q;
  pnr_pkg::op_t                op;

  assign op         = pnr_pkg::op_t'(in_ch.op);
  assign n          = pnr_pkg::taps_now(taps_r);
  assign branch     = pnr_pkg::branch_of(phase_r, pbits_r);
  assign inc_eff    = (mode_r && inc_r < pnr_pkg::MIN_INTERP_INC) ?
                      pnr_pkg::MIN_INTERP_INC : inc_r;
  assign next_phase = {1'b0, phase_r} + {1'b0, inc_eff};
  assign carry      = next_phase[32];
  assign rev_j      = n - CW'(1) - j_r;
  assign tap_addr   = mode_r ? j_r[TW-1:0] : rev_j[TW-1:0];
  assign dl_idx     = head_r + j_r[TW-1:0];
  assign issue      = (state_r == pnr_pkg::ST_WALK) && (j_r < n);
  assign walk_done  = (j_r == n) && !s1_v_r && !s2_v_r;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign add_i      = mode_r ? acc_i_r : integ_i_r[s2_j_r];
  assign add_q      = mode_r ? acc_q_r : integ_q_r[s2_j_r];

  pnr_coef_ram u_coef (
    .clk   (clk),
    .we    (in_acc && op == pnr_pkg::OP_COEF),
    .waddr ({in_ch.coef_branch, in_ch.coef_tap}),
    .wdata (in_ch.coef_value),
    .raddr ({branch, tap_addr}),
    .rdata (coef_q)
  );

  pnr_mac u_mac (
    .clk   (clk),
    .en    (s1_v_r),
    .coef  (coef_q),
    .x_i   (opnd_i_r),
    .x_q   (opnd_q_r),
    .add_i (add_i),
    .add_q (add_q),
    .sum_i (sum_i),
    .sum_q (sum_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pnr_pkg::ST_IDLE: begin
        if (in_acc && op == pnr_pkg::OP_SAMPLE) begin
          state_nxt = pnr_pkg::ST_WALK;
        end
      end
      pnr_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = pnr_pkg::ST_POST;
        end
      end
      pnr_pkg::ST_POST: begin
        if (mode_r) begin
          if (slot_free) begin
            state_nxt = carry ? pnr_pkg::ST_IDLE : pnr_pkg::ST_WALK;
          end
        end else begin
          state_nxt = carry ? pnr_pkg::ST_DUMP : pnr_pkg::ST_IDLE;
        end
      end
      pnr_pkg::ST_DUMP: state_nxt = pnr_pkg::ST_GAIN;
      pnr_pkg::ST_GAIN: state_nxt = pnr_pkg::ST_EMIT;
      pnr_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = pnr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pnr_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      pnr_pkg::ST_IDLE: in_ch.ready = 1'b1;
      pnr_pkg::ST_POST: out_load = mode_r && slot_free;
      pnr_pkg::ST_EMIT: out_load = slot_free;
      default: begin
        in_ch.ready = 1'b0;
        out_load    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      inc_r   <= 32'h8000_0000;
      pbits_r <= 3'd6;
      taps_r  <= 6'd32;
      gain_r  <= 16'h8000;
    end else if (cfg_we) begin
      case (pnr_pkg::cfg_idx_t'(cfg_idx))
        pnr_pkg::CFG_INTERP_MODE: mode_r  <= cfg_wdata[0];
        pnr_pkg::CFG_PHASE_INC:   inc_r   <= cfg_wdata;
        pnr_pkg::CFG_PHASE_BITS:  pbits_r <= cfg_wdata[2:0];
        pnr_pkg::CFG_TAPS:        taps_r  <= cfg_wdata[5:0];
        pnr_pkg::CFG_DECIM_GAIN:  gain_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // tap walk pipeline: issue -> coef/operand -> product -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
    s1_j_r <= j_r[TW-1:0];
    s2_j_r <= s1_j_r;
    if (issue) begin
      opnd_i_r <= mode_r ? dl_i_r[dl_idx] : x_i_r;
      opnd_q_r <= mode_r ? dl_q_r[dl_idx] : x_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pnr_pkg::ST_IDLE && in_acc && op == pnr_pkg::OP_SAMPLE) begin
      x_i_r   <= in_ch.sample_i;
      x_q_r   <= in_ch.sample_q;
      j_r     <= '0;
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (state_r == pnr_pkg::ST_POST && mode_r && slot_free && !carry) begin
      j_r     <= '0;
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else begin
      if (issue) begin
        j_r <= j_r + CW'(1);
      end
      if (s2_v_r && mode_r) begin
        acc_i_r <= sum_i;
        acc_q_r <= sum_q;
      end
    end
    if (state_r == pnr_pkg::ST_GAIN) begin
      g_i_r <= y_i_r * $signed({1'b0, gain_r});
      g_q_r <= y_q_r * $signed({1'b0, gain_r});
    end
  end

  // running state: phase, delay line, integrators, transposed line
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && op == pnr_pkg::OP_CLEAR)) begin
      phase_r <= '0;
      head_r  <= '0;
      for (int k = 0; k < NT; k++) begin
        dl_i_r[k]    <= '0;
        dl_q_r[k]    <= '0;
        integ_i_r[k] <= '0;
        integ_q_r[k] <= '0;
      end
      for (int k = 0; k < NT-1; k++) begin
        tdl_i_r[k] <= '0;
        tdl_q_r[k] <= '0;
      end
    end else begin
      if (s2_v_r && !mode_r) begin
        integ_i_r[s2_j_r] <= sum_i;
        integ_q_r[s2_j_r] <= sum_q;
      end
      if (state_r == pnr_pkg::ST_POST && (!mode_r || slot_free)) begin
        phase_r <= next_phase[31:0];
        if (mode_r && carry) begin
          head_r                  <= head_r - TW'(1);
          dl_i_r[head_r - TW'(1)] <= x_i_r;
          dl_q_r[head_r - TW'(1)] <= x_q_r;
        end
      end
      if (state_r == pnr_pkg::ST_DUMP) begin
        if (n == CW'(1)) begin
          y_i_r <= integ_i_r[0];
          y_q_r <= integ_q_r[0];
        end else begin
          y_i_r <= pnr_pkg::sat_add(integ_i_r[0], tdl_i_r[0]);
          y_q_r <= pnr_pkg::sat_add(integ_q_r[0], tdl_q_r[0]);
        end
        for (int k = 0; k < NT-1; k++) begin
          if (7'(k + 2) < {1'b0, n}) begin
            tdl_i_r[k] <= pnr_pkg::sat_add(integ_i_r[k+1], tdl_i_r[k+1]);
            tdl_q_r[k] <= pnr_pkg::sat_add(integ_q_r[k+1], tdl_q_r[k+1]);
          end else if (7'(k + 2) == {1'b0, n}) begin
            tdl_i_r[k] <= integ_i_r[k+1];
            tdl_q_r[k] <= integ_q_r[k+1];
          end
        end
        for (int k = 0; k < NT; k++) begin
          integ_i_r[k] <= '0;
          integ_q_r[k] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      if (state_r == pnr_pkg::ST_POST) begin
        out_i_r    <= pnr_pkg::round_acc(acc_i_r);
        out_q_r    <= pnr_pkg::round_acc(acc_q_r);
        out_last_r <= carry;
      end else begin
        out_i_r    <= pnr_pkg::round_gain(g_i_r);
        out_q_r    <= pnr_pkg::round_gain(g_q_r);
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;
  assign out_ch.last  = out_last_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking testbench for polyphase_nco_resampler
// Loads the coefficients that each register setting reads, then runs directed
// and random items through several settings in both interpolate and decimate
// mode. A built-in predictor computes every expected result, and a monitor
// checks the results field by field in order. Both channels idle and stall.
// ---------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 120;

  typedef struct {
    pnr_pkg::op_t       op;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [5:0]         br;
    logic [4:0]         tp;
    logic signed [15:0] cv;
    bit                 drain;
  } item_t;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               last;
  } iq_res_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  pnr_in_if  in_ch();
  pnr_out_if out_ch();

  polyphase_nco_resampler u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  item_t   pending_items[$];
  iq_res_t expected_iq[$];
  int      errors;
  int      results_seen;
  int      samples_sent;
  int      cycles;
  bit      idle_en;

  // predictor copy of registers and running state
  bit                 mode_interp;
  logic [31:0]        step_reg;
  logic [2:0]         pbits_reg;
  logic [5:0]         taps_reg;
  logic [15:0]        gain_reg;
  logic [31:0]        nco_phase;
  logic signed [15:0] coef_mem [pnr_pkg::COEF_DEPTH];
  longint             line_i [pnr_pkg::MAX_TAPS];
  longint             line_q [pnr_pkg::MAX_TAPS];
  int                 line_head;
  longint             int_i [pnr_pkg::MAX_TAPS];
  longint             int_q [pnr_pkg::MAX_TAPS];
  longint             tline_i [pnr_pkg::MAX_TAPS-1];
  longint             tline_q [pnr_pkg::MAX_TAPS-1];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_acc(longint v);
    longint hi;
    hi = (longint'(1) <<< (pnr_pkg::ACC_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // round half up then shift; arithmetic shift gives floor
  function automatic logic signed [15:0] round_sat(longint v, int sh);
    longint r;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic int branch_base(logic [31:0] ph);
    int b;
    b = (pbits_reg > 3'd6) ? 6 : int'(pbits_reg);
    return (b == 0) ? 0 : int'(ph >> (32 - b)) * pnr_pkg::MAX_TAPS;
  endfunction

  function automatic int taps_eff();
    if (taps_reg == 0) return 1;
    if (taps_reg > 6'd32) return pnr_pkg::MAX_TAPS;
    return int'(taps_reg);
  endfunction

  task automatic clear_running();
    nco_phase = '0;
    line_head = 0;
    for (int k = 0; k < pnr_pkg::MAX_TAPS; k++) begin
      line_i[k] = 0; line_q[k] = 0; int_i[k] = 0; int_q[k] = 0;
      if (k < pnr_pkg::MAX_TAPS - 1) begin
        tline_i[k] = 0; tline_q[k] = 0;
      end
    end
  endtask

  task automatic predict_resampler(item_t it);
    int          n;
    int          base;
    int          p;
    logic [31:0] inc;
    logic [31:0] nxt;
    bit          carry;
    longint      ai;
    longint      aq;
    longint      h;
    iq_res_t     r;
    n = taps_eff();
    case (it.op)
      pnr_pkg::OP_COEF: coef_mem[{it.br, it.tp}] = it.cv;
      pnr_pkg::OP_CLEAR: clear_running();
      pnr_pkg::OP_SAMPLE: begin
        samples_sent++;
        if (mode_interp) begin
          inc = (step_reg < pnr_pkg::MIN_INTERP_INC) ? pnr_pkg::MIN_INTERP_INC : step_reg;
          carry = 1'b0;
          while (!carry) begin
            base = branch_base(nco_phase);
            ai = 0;
            aq = 0;
            for (int j = 0; j < n; j++) begin
              p = (line_head + j) % pnr_pkg::MAX_TAPS;
              h = longint'(coef_mem[base + j]);
              ai = sat_acc(ai + line_i[p] * h);
              aq = sat_acc(aq + line_q[p] * h);
            end
            nxt = nco_phase + inc;
            carry = nxt < nco_phase;
            nco_phase = nxt;
            r.i = round_sat(ai, 15);
            r.q = round_sat(aq, 15);
            r.last = carry;
            expected_iq.push_back(r);
          end
          line_head = (line_head + pnr_pkg::MAX_TAPS - 1) % pnr_pkg::MAX_TAPS;
          line_i[line_head] = longint'(it.si);
          line_q[line_head] = longint'(it.sq);
        end else begin
          base = branch_base(nco_phase);
          for (int j = 0; j < n; j++) begin
            h = longint'(coef_mem[base + n - 1 - j]);
            int_i[j] = sat_acc(int_i[j] + longint'(it.si) * h);
            int_q[j] = sat_acc(int_q[j] + longint'(it.sq) * h);
          end
          nxt = nco_phase + step_reg;
          carry = nxt < nco_phase;
          nco_phase = nxt;
          if (carry) begin
            if (n == 1) begin
              ai = int_i[0];
              aq = int_q[0];
            end else begin
              ai = sat_acc(int_i[0] + tline_i[0]);
              aq = sat_acc(int_q[0] + tline_q[0]);
              for (int j = 0; j + 2 < n; j++) begin
                tline_i[j] = sat_acc(int_i[j+1] + tline_i[j+1]);
                tline_q[j] = sat_acc(int_q[j+1] + tline_q[j+1]);
              end
              tline_i[n-2] = int_i[n-1];
              tline_q[n-2] = int_q[n-1];
            end
            r.i = round_sat(ai * longint'(gain_reg), 31);
            r.q = round_sat(aq * longint'(gain_reg), 31);
            r.last = 1'b1;
            expected_iq.push_back(r);
            for (int j = 0; j < pnr_pkg::MAX_TAPS; j++) begin
              int_i[j] = 0; int_q[j] = 0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  item_t cur_item;
  int    send_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_resampler(cur_item);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_iq.size() > 0)) begin
          cur_item = pending_items.pop_front();
          in_ch.op          <= cur_item.op;
          in_ch.sample_i    <= cur_item.si;
          in_ch.sample_q    <= cur_item.sq;
          in_ch.coef_branch <= cur_item.br;
          in_ch.coef_tap    <= cur_item.tp;
          in_ch.coef_value  <= cur_item.cv;
          in_ch.valid       <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result stall
  int stall_left;
  always @(posedge clk) begin
    iq_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_iq.size() == 0) begin
          errors++;
          $display("%0t: unexpected result i=%0d q=%0d last=%0b", $time,
                   out_ch.out_i, out_ch.out_q, out_ch.last);
        end else begin
          e = expected_iq.pop_front();
          if (out_ch.out_i !== e.i || out_ch.out_q !== e.q || out_ch.last !== e.last) begin
            errors++;
            $display("%0t: mismatch exp i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                     $time, e.i, e.q, e.last, out_ch.out_i, out_ch.out_q, out_ch.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void push_item(pnr_pkg::op_t op, logic signed [15:0] si,
                                    logic signed [15:0] sq, logic [5:0] br, logic [4:0] tp,
                                    logic signed [15:0] cv, bit drain);
    item_t it;
    it.op = op; it.si = si; it.sq = sq; it.br = br; it.tp = tp; it.cv = cv;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  function automatic logic signed [15:0] rand_val();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return 16'($urandom());
  endfunction

  // write the coefficient block a setting reads, bounds inclusive
  function automatic void push_fill(int br_lo, int br_hi, int tp_lo, int tp_hi);
    for (int b = br_lo; b <= br_hi; b++)
      for (int t = tp_lo; t <= tp_hi; t++)
        push_item(pnr_pkg::OP_COEF, '0, '0, 6'(b), 5'(t), rand_val(), 1'b0);
  endfunction

  function automatic void push_clear();
    push_item(pnr_pkg::OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
  endfunction

  function automatic void push_random(int count);
    int  r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)
        push_item(pnr_pkg::OP_SAMPLE, rand_val(), rand_val(), '0, '0, '0, 1'b0);
      else if (r < 90)
        push_item(pnr_pkg::OP_COEF, 16'($urandom()), 16'($urandom()), 6'($urandom()),
                  5'($urandom()), rand_val(), 1'b0);
      else if (r < 96)
        push_item(pnr_pkg::OP_CLEAR, 16'($urandom()), 16'($urandom()), 6'($urandom()),
                  5'($urandom()), 16'($urandom()), 1'b0);
      else
        push_item(pnr_pkg::OP_NONE, 16'($urandom()), 16'($urandom()), 6'($urandom()),
                  5'($urandom()), 16'($urandom()), 1'b0);
    end
  endfunction

  // sample after the edge so the driver's updates have landed
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() > 0 || in_ch.valid || !in_ch.ready ||
               expected_iq.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(pnr_pkg::cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      pnr_pkg::CFG_INTERP_MODE: mode_interp = val[0];
      pnr_pkg::CFG_PHASE_INC:   step_reg = val;
      pnr_pkg::CFG_PHASE_BITS:  pbits_reg = val[2:0];
      pnr_pkg::CFG_TAPS:        taps_reg = val[5:0];
      pnr_pkg::CFG_DECIM_GAIN:  gain_reg = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(bit md, logic [31:0] inc, logic [2:0] pb, logic [5:0] tp,
                          logic [15:0] g);
    wait_idle();
    write_reg(pnr_pkg::CFG_INTERP_MODE, {31'd0, md});
    write_reg(pnr_pkg::CFG_PHASE_INC, inc);
    write_reg(pnr_pkg::CFG_PHASE_BITS, {29'd0, pb});
    write_reg(pnr_pkg::CFG_TAPS, {26'd0, tp});
    write_reg(pnr_pkg::CFG_DECIM_GAIN, {16'd0, g});
  endtask

  initial begin
    errors = 0; results_seen = 0; samples_sent = 0; cycles = 0; idle_en = 1'b0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.op = pnr_pkg::OP_NONE; in_ch.sample_i = '0;
    in_ch.sample_q = '0; in_ch.coef_branch = '0; in_ch.coef_tap = '0;
    in_ch.coef_value = '0;
    out_ch.ready = 1'b0;
    mode_interp = 1'b1; step_reg = 32'h8000_0000; pbits_reg = 3'd6; taps_reg = 6'd32;
    gain_reg = 16'h8000;
    clear_running();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // interpolate over two branches of four taps; extremes, every op, clear
    set_regs(1'b1, 32'h8000_0000, 3'd1, 6'd4, 16'h8000);
    push_fill(0, 1, 0, 3);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh7fff, 16'sh8000, '0, '0, '0, 1'b0);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh8000, 16'sh7fff, '0, '0, '0, 1'b0);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh7fff, 16'sh7fff, '0, '0, '0, 1'b0);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh8000, 16'sh8000, '0, '0, '0, 1'b0);
    push_item(pnr_pkg::OP_COEF, '0, '0, 6'd63, 5'd31, 16'sh8000, 1'b0);
    push_item(pnr_pkg::OP_COEF, '0, '0, 6'd0, 5'd0, 16'sh7fff, 1'b0);
    push_item(pnr_pkg::OP_NONE, 16'sh7fff, 16'sh7fff, 6'd63, 5'd31, 16'sh7fff, 1'b0);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh0001, 16'shffff, '0, '0, '0, 1'b0);
    push_clear();
    push_item(pnr_pkg::OP_SAMPLE, 16'sh8000, 16'sh7fff, '0, '0, '0, 1'b1);
    idle_en = 1'b1;
    push_random(8);

    // small step clamp, zero taps
    set_regs(1'b1, 32'd1, 3'd1, 6'd0, 16'hffff);
    push_clear();
    push_item(pnr_pkg::OP_SAMPLE, 16'sh7fff, 16'sh8000, '0, '0, '0, 1'b0);
    push_random(4);

    // oversized phase bits: half steps from zero reach branches 0 and 32
    set_regs(1'b1, 32'h8000_0000, 3'd7, 6'd0, 16'hffff);
    push_clear();
    push_fill(32, 32, 0, 0);
    push_random(5);

    // decimate, single tap, full gain
    set_regs(1'b0, 32'h4000_0000, 3'd2, 6'd1, 16'hffff);
    push_clear();
    push_fill(2, 3, 0, 0);
    push_random(8);

    // decimate, largest step, no phase bits, zero gain
    set_regs(1'b0, 32'hffff_ffff, 3'd0, 6'd8, 16'h0000);
    idle_en = 1'b0;
    push_clear();
    push_fill(0, 0, 4, 7);
    push_random(8);

    // decimate with a tiny step: no carry, no results
    set_regs(1'b0, 32'd1, 3'd6, 6'd5, 16'h8000);
    push_clear();
    push_random(4);

    // interpolate with oversized tap count
    set_regs(1'b1, 32'h9000_0000, 3'd0, 6'd63, 16'h1234);
    idle_en = 1'b1;
    push_clear();
    push_fill(0, 0, 8, 31);
    push_random(6);

    // decimate with random gain and a sender hold-off
    set_regs(1'b0, 32'h2aaa_aaab, 3'd1, 6'd4, 16'(($urandom())));
    push_clear();
    push_random(6);
    push_item(pnr_pkg::OP_SAMPLE, 16'sh1234, 16'shedcb, '0, '0, '0, 1'b1);
    push_random(6);

    wait_idle();
    $display("Covered %0d samples and %0d results over eight register settings,",
             samples_sent, results_seen);
    $display("both modes, clamps, single tap and coefficient rewrites.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
